### hw/rtl/lhbp_pkg.sv
package lhbp_pkg;

	// table geometry
	localparam int PATTERN_INDEX_BITS       = 12;
	localparam int HISTORY_TABLE_INDEX_BITS = 8;
	localparam int HISTORY_BITS             = 4;

	// sweep counter covers the larger of the two tables
	localparam int CLEAR_BITS = (PATTERN_INDEX_BITS > HISTORY_TABLE_INDEX_BITS) ?
		PATTERN_INDEX_BITS : HISTORY_TABLE_INDEX_BITS;

	typedef logic [PATTERN_INDEX_BITS-1:0]       pidx_t;
	typedef logic [HISTORY_TABLE_INDEX_BITS-1:0] hsel_t;
	typedef logic [HISTORY_BITS-1:0]             hist_t;
	typedef logic [CLEAR_BITS-1:0]               clr_t;
	typedef logic [1:0]                          ctr_t;

	// counter reset value and saturation bounds
	localparam ctr_t CTR_WEAK_TAKEN = 2'd2;
	localparam ctr_t CTR_MAX        = 2'd3;
	localparam ctr_t CTR_MIN        = 2'd0;
	localparam hist_t HIST_RESET    = '0;

endpackage

### hw/rtl/local_history_branch_predictor_unit.sv
// Channel   Ports                          Direction  Handshake
// item      branch_address, taken          in         start high while busy low
// result    predict_taken                  out        done high for one cycle
//
// Each word steps through history read, pattern read, then the result
// with counter write-back, in the order the two registered reads set.
// After reset a clearing pass over 2^CLEAR_BITS addresses (4096 here)
// loads the pattern table with weakly taken and the history table with
// zeros; busy stays high meanwhile. The receiver cannot stall: done marks
// the only cycle in which predict_taken is valid.
module local_history_branch_predictor_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] branch_address,
	input  logic        taken,
	output logic        done,
	output logic        predict_taken
);

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_HIST,
		S_PAT
	} state_t;

	localparam int PIB = lhbp_pkg::PATTERN_INDEX_BITS;
	localparam int HTB = lhbp_pkg::HISTORY_TABLE_INDEX_BITS;
	localparam int HB  = lhbp_pkg::HISTORY_BITS;

	state_t          state_q;
	lhbp_pkg::clr_t  clr_q;
	lhbp_pkg::pidx_t addr_s1;
	lhbp_pkg::hsel_t hsel_s1;
	logic            taken_s1;
	lhbp_pkg::pidx_t pidx_s2;

	// memories and registered read data
	lhbp_pkg::ctr_t  pat_mem [2**PIB];
	lhbp_pkg::hist_t hist_mem [2**HTB];
	lhbp_pkg::hist_t hist_rd_q;
	lhbp_pkg::ctr_t  ctr_rd_q;

	logic            hist_we;
	lhbp_pkg::hsel_t hist_waddr;
	lhbp_pkg::hist_t hist_wdata;
	logic            pat_we;
	lhbp_pkg::pidx_t pat_waddr;
	lhbp_pkg::ctr_t  pat_wdata;
	lhbp_pkg::hsel_t hist_raddr;
	lhbp_pkg::pidx_t pat_raddr;
	logic            accept;
	logic [PIB+HB-1:0] idx_wide;
	logic [HB:0]     hist_shift;

	assign accept     = start && (state_q == S_IDLE);
	assign busy       = (state_q != S_IDLE);
	assign done       = (state_q == S_PAT);
	assign predict_taken = ctr_rd_q[1];

	// pattern index: address bits above, history below, low bits kept
	assign idx_wide   = {addr_s1, hist_rd_q};
	assign pat_raddr  = idx_wide[PIB-1:0];
	assign hist_raddr = branch_address[HTB+1:2];
	assign hist_shift = {hist_rd_q, taken_s1};

	// write port select: clearing sweep or item update
	always_comb begin
		hist_we    = 1'b0;
		hist_waddr = hsel_s1;
		hist_wdata = hist_shift[HB-1:0];
		pat_we     = 1'b0;
		pat_waddr  = pidx_s2;
		pat_wdata  = ctr_rd_q;
		unique case (state_q)
			S_CLEAR: begin
				hist_we    = 1'b1;
				hist_waddr = clr_q[HTB-1:0];
				hist_wdata = lhbp_pkg::HIST_RESET;
				pat_we     = 1'b1;
				pat_waddr  = clr_q[PIB-1:0];
				pat_wdata  = lhbp_pkg::CTR_WEAK_TAKEN;
			end
			S_HIST: begin
				hist_we = 1'b1;
			end
			S_PAT: begin
				pat_we = 1'b1;
				if (taken_s1) begin
					if (ctr_rd_q != lhbp_pkg::CTR_MAX) pat_wdata = ctr_rd_q + 2'd1;
				end else begin
					if (ctr_rd_q != lhbp_pkg::CTR_MIN) pat_wdata = ctr_rd_q - 2'd1;
				end
			end
			default: begin
			end
		endcase
	end

	// history table
	always_ff @(posedge clk) begin
		if (hist_we) hist_mem[hist_waddr] <= hist_wdata;
		hist_rd_q <= hist_mem[hist_raddr];
	end

	// pattern table
	always_ff @(posedge clk) begin
		if (pat_we) pat_mem[pat_waddr] <= pat_wdata;
		ctr_rd_q <= pat_mem[pat_raddr];
	end

	// item registers
	always_ff @(posedge clk) begin
		if (accept) begin
			addr_s1  <= branch_address[PIB+1:2];
			hsel_s1  <= hist_raddr;
			taken_s1 <= taken;
		end
		if (state_q == S_HIST) pidx_s2 <= pat_raddr;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == '1) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (accept) state_q <= S_HIST;
				end
				S_HIST: begin
					state_q <= S_PAT;
				end
				S_PAT: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

### test/lhbp_predict_checker.sv
`timescale 1ns / 1ps

// Watches the item and result channels, keeps its own copy of both tables
// and checks every result word against the prediction worked out at accept.
module lhbp_predict_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [31:0] branch_address,
	input  logic        taken,
	input  logic        done,
	input  logic        predict_taken,
	output int          fail_count,
	output int          pending
);

	lhbp_pkg::ctr_t  counter_tbl [2**lhbp_pkg::PATTERN_INDEX_BITS];
	lhbp_pkg::hist_t history_tbl [2**lhbp_pkg::HISTORY_TABLE_INDEX_BITS];
	logic            expected_predictions [$];
	int              mismatches;

	// one line per mismatch, then count it
	task automatic report_mismatch(input string what);
		$display("[%0t] mismatch: %s", $time, what);
		mismatches++;
	endtask

	// look up the counter for this branch, then train counter and history
	task automatic predict_and_train(input logic [31:0] addr, input logic outcome,
			output logic guess);
		lhbp_pkg::hsel_t sel;
		lhbp_pkg::hist_t hist;
		lhbp_pkg::pidx_t idx;
		lhbp_pkg::ctr_t  ctr;
		logic [63:0]     raw_idx;
		sel = lhbp_pkg::hsel_t'(addr >> 2);
		hist = history_tbl[sel];
		// address bits sit above the history; truncation drops what does not fit
		raw_idx = (64'(addr >> 2) << lhbp_pkg::HISTORY_BITS) | 64'(hist);
		idx = lhbp_pkg::pidx_t'(raw_idx);
		ctr = counter_tbl[idx];
		guess = (ctr >= lhbp_pkg::CTR_WEAK_TAKEN);
		if (outcome && ctr != lhbp_pkg::CTR_MAX)
			ctr = ctr + 2'd1;
		else if (!outcome && ctr != lhbp_pkg::CTR_MIN)
			ctr = ctr - 2'd1;
		counter_tbl[idx] = ctr;
		history_tbl[sel] = lhbp_pkg::hist_t'({hist, outcome});
	endtask

	// results are retired before the item of the same edge is taken in
	always @(posedge clk or negedge arst_n) begin
		logic want;
		logic guess;
		if (!arst_n) begin
			foreach (counter_tbl[i])
				counter_tbl[i] = lhbp_pkg::CTR_WEAK_TAKEN;
			foreach (history_tbl[i])
				history_tbl[i] = lhbp_pkg::HIST_RESET;
			expected_predictions.delete();
			mismatches = 0;
			fail_count <= 0;
			pending <= 0;
		end else begin
			if (done) begin
				if (expected_predictions.size() == 0) begin
					report_mismatch("result word with no item outstanding");
				end else begin
					want = expected_predictions.pop_front();
					if (predict_taken !== want)
						report_mismatch($sformatf("predict_taken %b, expected %b",
							predict_taken, want));
				end
			end
			if (start && !busy) begin
				predict_and_train(branch_address, taken, guess);
				expected_predictions.push_back(guess);
			end
			fail_count <= mismatches;
			pending <= expected_predictions.size();
		end
	end

endmodule

### test/local_history_branch_predictor_unit_tb.sv
`timescale 1ns / 1ps

module local_history_branch_predictor_unit_tb;

	localparam int QUIET_LIMIT = 20000;
	localparam int POOL_SIZE = 16;
	localparam int WORDS_PER_PHASE = 200;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic [31:0] branch_address = '0;
	logic        taken = 1'b0;
	logic        busy;
	logic        done;
	logic        predict_taken;
	int          fail_count;
	int          pending;
	int          quiet_cycles = 0;

	logic [31:0] branch_pool [POOL_SIZE];
	int          trip_count [POOL_SIZE];
	int          trip_pos [POOL_SIZE];
	int          idle_pct [4] = '{0, 65, 19, 0};

	local_history_branch_predictor_unit dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.branch_address (branch_address),
		.taken          (taken),
		.done           (done),
		.predict_taken  (predict_taken)
	);

	lhbp_predict_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.branch_address (branch_address),
		.taken          (taken),
		.done           (done),
		.predict_taken  (predict_taken),
		.fail_count     (fail_count),
		.pending        (pending)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// watchdog: cycles with neither an accepted item nor a result word
	always @(posedge clk) begin
		if ((start && !busy) || done) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// drive one item word, then wait until busy is seen low
	task automatic send_branch(input logic [31:0] addr, input logic outcome);
		start <= 1'b1;
		branch_address <= addr;
		taken <= outcome;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	// random idle cycles with junk on the payload
	task automatic idle_gaps(input int pct);
		while ($urandom_range(0, 99) < pct) begin
			start <= 1'b0;
			branch_address <= $urandom;
			taken <= 1'($urandom_range(0, 1));
			@(posedge clk);
		end
	endtask

	// odd entries alias the even ones below bit 16 but differ above
	task automatic refill_pool();
		for (int i = 0; i < POOL_SIZE; i++) begin
			if (i[0])
				branch_pool[i] = ($urandom & 32'hFFFF_0000) |
					(branch_pool[i-1] & 32'h0000_FFFF);
			else
				branch_pool[i] = $urandom;
			trip_count[i] = $urandom_range(2, 6);
			trip_pos[i] = 0;
		end
	endtask

	initial begin
		int pick;
		int mode;
		logic outcome;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// directed: saturate up, saturate down, aliasing, ignored low bits
		repeat (8) send_branch(32'h0000_0000, 1'b1);
		repeat (8) send_branch(32'hFFFF_C000, 1'b0);
		repeat (4) send_branch(32'hFFFF_FFFF, 1'b0);
		send_branch(32'h0000_0003, 1'b1);
		for (int k = 0; k < 4; k++)
			send_branch(32'h0000_0004, k[0]);

		// random: mostly loop-like branches from a small pool, some noise
		foreach (idle_pct[p]) begin
			refill_pool();
			repeat (WORDS_PER_PHASE) begin
				idle_gaps(idle_pct[p]);
				mode = $urandom_range(0, 99);
				pick = $urandom_range(0, POOL_SIZE - 1);
				if (mode < 60) begin
					outcome = (trip_pos[pick] != trip_count[pick] - 1);
					trip_pos[pick] = (trip_pos[pick] + 1) % trip_count[pick];
					send_branch(branch_pool[pick], outcome);
				end else if (mode < 80) begin
					send_branch(branch_pool[pick], 1'($urandom_range(0, 1)));
				end else begin
					send_branch($urandom, 1'($urandom_range(0, 1)));
				end
			end
		end
		start <= 1'b0;

		// drain, then allow time for any stray result word
		while (pending != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

### files.f
hw/rtl/lhbp_pkg.sv
hw/rtl/local_history_branch_predictor_unit.sv
test/lhbp_predict_checker.sv
test/local_history_branch_predictor_unit_tb.sv
